>>> src/utf8_to_codepoint_decoder_assert.svh
// Assertion macros for the UTF-8 decoder.
`ifndef UTF8_TO_CODEPOINT_DECODER_ASSERT_SVH
`define UTF8_TO_CODEPOINT_DECODER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while in reset.
`define U8DEC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define U8DEC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define U8DEC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define U8DEC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> src/u8dec_pkg.sv
package u8dec_pkg;

  localparam int CP_W  = 21;
  localparam int PTS_W = 32;

  localparam logic [CP_W-1:0] REPL_CP = 21'h00FFFD;

  // Byte class masks and tags
  localparam logic [7:0] ASCII_MASK = 8'h80;
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_TAG   = 8'h80;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_TAG  = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_TAG  = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_TAG  = 8'hF0;

  // Payload masks
  localparam logic [7:0] CONT_BITS  = 8'h3F;
  localparam logic [7:0] LEAD2_BITS = 8'h1F;
  localparam logic [7:0] LEAD3_BITS = 8'h0F;
  localparam logic [7:0] LEAD4_BITS = 8'h07;

  // Sequence length minus one
  localparam logic [1:0] LEN_NONE = 2'd0;
  localparam logic [1:0] LEN_TWO  = 2'd1;
  localparam logic [1:0] LEN_THREE = 2'd2;
  localparam logic [1:0] LEN_FOUR = 2'd3;

  typedef struct packed {
    logic [CP_W-1:0]  code_point;
    logic             is_replacement;
    logic             malformed_so_far;
    logic [PTS_W-1:0] points_so_far;
    logic             last;
  } result_t;

endpackage

>>> src/u8dec_in_if.sv
interface u8dec_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_string;

  modport source (output valid, output data_byte, output end_of_string, input ready);
  modport sink   (input valid, input data_byte, input end_of_string, output ready);
endinterface

>>> src/u8dec_out_if.sv
interface u8dec_out_if;
  logic                        valid;
  logic                        ready;
  logic [u8dec_pkg::CP_W-1:0]  code_point;
  logic                        is_replacement;
  logic                        malformed_so_far;
  logic [u8dec_pkg::PTS_W-1:0] points_so_far;
  logic                        last;

  modport source (output valid, output code_point, output is_replacement,
                  output malformed_so_far, output points_so_far, output last,
                  input ready);
  modport sink   (input valid, input code_point, input is_replacement,
                  input malformed_so_far, input points_so_far, input last,
                  output ready);
endinterface

>>> src/u8dec_core.sv
`include "utf8_to_codepoint_decoder_assert.svh"

module u8dec_core #(
  parameter int COUNT_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  logic [7:0]          data_byte,
  input  logic                end_of_string,
  output logic                emit,
  output u8dec_pkg::result_t  result
);

  logic                       in_seq_r, in_seq_nxt;
  logic [1:0]                 exp_len_r, exp_len_nxt;
  logic [1:0]                 taken_r, taken_nxt;
  logic [u8dec_pkg::CP_W-1:0] partial_r, partial_nxt;
  logic                       err_r, err_nxt;
  logic [COUNT_BITS-1:0]      cnt_r, cnt_nxt;

  logic [COUNT_BITS-1:0]      cnt_inc;
  logic [u8dec_pkg::PTS_W-1:0] pts;
  logic [u8dec_pkg::CP_W-1:0] acc;
  logic [u8dec_pkg::CP_W-1:0] cp;
  logic                       bad;
  logic                       open_seq;
  logic [2:0]                 taken_p1;

  assign acc      = {partial_r[u8dec_pkg::CP_W-7:0], data_byte[5:0]};
  assign taken_p1 = {1'b0, taken_r} + 3'd1;
  assign cnt_inc  = (&cnt_r) ? cnt_r : cnt_r + {{(COUNT_BITS-1){1'b0}}, 1'b1};

  // Count shown on the port, clamped to 32 bits
  generate
    if (COUNT_BITS > u8dec_pkg::PTS_W) begin : g_wide
      assign pts = (|cnt_inc[COUNT_BITS-1:u8dec_pkg::PTS_W]) ? '1
                   : cnt_inc[u8dec_pkg::PTS_W-1:0];
    end else if (COUNT_BITS == u8dec_pkg::PTS_W) begin : g_same
      assign pts = cnt_inc;
    end else begin : g_narrow
      assign pts = {{(u8dec_pkg::PTS_W-COUNT_BITS){1'b0}}, cnt_inc};
    end
  endgenerate

  always_comb begin
    in_seq_nxt  = in_seq_r;
    exp_len_nxt = exp_len_r;
    taken_nxt   = taken_r;
    partial_nxt = partial_r;
    emit        = 1'b0;
    bad         = 1'b0;
    cp          = '0;

    if (!in_seq_r) begin
      if ((data_byte & u8dec_pkg::ASCII_MASK) == 8'h00) begin
        emit = 1'b1;
        cp   = {13'd0, data_byte};
      end else if ((data_byte & u8dec_pkg::LEAD2_MASK) == u8dec_pkg::LEAD2_TAG) begin
        in_seq_nxt  = 1'b1;
        exp_len_nxt = u8dec_pkg::LEN_TWO;
        taken_nxt   = 2'd0;
        partial_nxt = {13'd0, data_byte & u8dec_pkg::LEAD2_BITS};
      end else if ((data_byte & u8dec_pkg::LEAD3_MASK) == u8dec_pkg::LEAD3_TAG) begin
        in_seq_nxt  = 1'b1;
        exp_len_nxt = u8dec_pkg::LEN_THREE;
        taken_nxt   = 2'd0;
        partial_nxt = {13'd0, data_byte & u8dec_pkg::LEAD3_BITS};
      end else if ((data_byte & u8dec_pkg::LEAD4_MASK) == u8dec_pkg::LEAD4_TAG) begin
        in_seq_nxt  = 1'b1;
        exp_len_nxt = u8dec_pkg::LEN_FOUR;
        taken_nxt   = 2'd0;
        partial_nxt = {13'd0, data_byte & u8dec_pkg::LEAD4_BITS};
      end else begin
        // stray continuation or 0xF8..0xFF lead
        emit = 1'b1;
        bad  = 1'b1;
      end
    end else if ((data_byte & u8dec_pkg::CONT_MASK) == u8dec_pkg::CONT_TAG) begin
      if (taken_p1 >= {1'b0, exp_len_r}) begin
        emit        = 1'b1;
        cp          = acc;
        in_seq_nxt  = 1'b0;
        exp_len_nxt = u8dec_pkg::LEN_NONE;
        taken_nxt   = 2'd0;
        partial_nxt = '0;
      end else begin
        partial_nxt = acc;
        taken_nxt   = taken_p1[1:0];
      end
    end else begin
      // broken sequence: byte consumed, sequence dropped
      emit        = 1'b1;
      bad         = 1'b1;
      in_seq_nxt  = 1'b0;
      exp_len_nxt = u8dec_pkg::LEN_NONE;
      taken_nxt   = 2'd0;
      partial_nxt = '0;
    end

    open_seq = in_seq_nxt;
    if (end_of_string && open_seq) begin
      emit = 1'b1;
      bad  = 1'b1;
    end

    // string end clears everything
    if (end_of_string) begin
      in_seq_nxt  = 1'b0;
      exp_len_nxt = u8dec_pkg::LEN_NONE;
      taken_nxt   = 2'd0;
      partial_nxt = '0;
    end

    err_nxt = err_r;
    cnt_nxt = cnt_r;
    if (end_of_string) begin
      err_nxt = 1'b0;
      cnt_nxt = '0;
    end else if (emit) begin
      err_nxt = err_r | bad;
      cnt_nxt = cnt_inc;
    end

    result.code_point       = bad ? u8dec_pkg::REPL_CP : cp;
    result.is_replacement   = bad;
    result.malformed_so_far = err_r | bad;
    result.points_so_far    = pts;
    result.last             = end_of_string;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_seq_r  <= 1'b0;
      exp_len_r <= u8dec_pkg::LEN_NONE;
      taken_r   <= 2'd0;
      partial_r <= '0;
      err_r     <= 1'b0;
      cnt_r     <= '0;
    end else if (fire) begin
      in_seq_r  <= in_seq_nxt;
      exp_len_r <= exp_len_nxt;
      taken_r   <= taken_nxt;
      partial_r <= partial_nxt;
      err_r     <= err_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

  `U8DEC_ASSERT_IMP(a_idle_clean, clk, rst_n, !in_seq_r, exp_len_r == u8dec_pkg::LEN_NONE && taken_r == 2'd0, "idle decoder holds sequence state")
  `U8DEC_ASSERT_IMP(a_seq_consistent, clk, rst_n, in_seq_r, exp_len_r != u8dec_pkg::LEN_NONE && taken_r < exp_len_r, "open sequence has bad length or count")
  `U8DEC_ASSERT_NXT(a_eos_clears, clk, rst_n, fire && end_of_string, !in_seq_r && !err_r && cnt_r == '0, "string end did not clear state")
  `U8DEC_ASSERT_IMP(a_eos_emits, clk, rst_n, fire && end_of_string, emit, "string end produced no result")

endmodule

>>> src/u8dec_out_reg.sv
`include "utf8_to_codepoint_decoder_assert.svh"

module u8dec_out_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  u8dec_pkg::result_t result,
  output logic               free,
  u8dec_out_if.source        out_ch
);

  logic               valid_r;
  u8dec_pkg::result_t res_r;

  assign free = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (free) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      res_r <= result;
    end
  end

  assign out_ch.valid            = valid_r;
  assign out_ch.code_point       = res_r.code_point;
  assign out_ch.is_replacement   = res_r.is_replacement;
  assign out_ch.malformed_so_far = res_r.malformed_so_far;
  assign out_ch.points_so_far    = res_r.points_so_far;
  assign out_ch.last             = res_r.last;

  `U8DEC_ASSERT_IMP(a_repl_flags, clk, rst_n, valid_r && res_r.is_replacement, res_r.malformed_so_far, "replacement without malformed flag")
  `U8DEC_ASSERT_IMP(a_repl_value, clk, rst_n, valid_r && res_r.is_replacement, res_r.code_point == u8dec_pkg::REPL_CP, "replacement carries wrong code point")
  `U8DEC_ASSERT_IMP(a_count_nonzero, clk, rst_n, valid_r, res_r.points_so_far != '0, "result with zero count")

endmodule

>>> src/utf8_to_codepoint_decoder.sv
// Channel  Dir  Handshake     Request contents
// in_ch    in   valid/ready   data_byte[7:0], end_of_string
// out_ch   out  valid/ready   code_point[20:0], is_replacement, malformed_so_far,
//                             points_so_far[31:0], last
//
// One byte per cycle sustained while out_ch accepts; each request passes an input
// register, the decode logic, and an output register.
// Throughput is set by the single state update per byte in the decode stage.
// rst_n is synchronous, active low; it empties both stages and clears the
// sequence state, the error flag and the count.
// A stalled out_ch holds the decode stage, and in_ch back-pressures once both
// registers are full; no request is dropped.

module utf8_to_codepoint_decoder #(
  parameter int COUNT_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  u8dec_in_if.sink    in_ch,
  u8dec_out_if.source out_ch
);

  // Input register: one byte waiting for the decode stage
  logic       in_v_r;
  logic [7:0] byte_r;
  logic       eos_r;

  logic               out_free;
  logic               proc_fire;
  logic               emit;
  u8dec_pkg::result_t result;

  // A held byte is decoded as soon as the output register can take its result.
  // Bytes that produce no result still wait for a free slot, which keeps the
  // control simple and costs nothing at a steady rate.
  assign proc_fire   = in_v_r && out_free;
  assign in_ch.ready = !in_v_r || proc_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      byte_r <= in_ch.data_byte;
      eos_r  <= in_ch.end_of_string;
    end
  end

  // Decode stage: sequence state, sticky error, saturating count
  u8dec_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .fire          (proc_fire),
    .data_byte     (byte_r),
    .end_of_string (eos_r),
    .emit          (emit),
    .result        (result)
  );

  // Result register, decoupling the decode stage from out_ch
  u8dec_out_reg u_out (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (proc_fire && emit),
    .result (result),
    .free   (out_free),
    .out_ch (out_ch)
  );

endmodule
